### src/mphl_pkg.sv
// Shared constants, codes and command/status types for the minimal perfect hash lookup unit.
// No dependencies; imported by every module of the block.
package mphl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENT_W       = 12;
    localparam int HASH_W      = 32;
    localparam int MOD_W       = 13;
    localparam int MAX_KEYS    = 4096;
    localparam int BYTE_W      = 8;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 16;
    localparam int SUM_STEPS   = MOD_W;
    localparam int CNT_W       = $clog2(HASH_W);

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd3;

    typedef struct packed {
        logic              clear;      // write zero at clr_addr
        logic [ADDR_W-1:0] clr_addr;
        logic              wr_entry;   // table write from the input beat
        logic              byte_step;  // fold key byte into both hashes
        logic              empty_key;  // restart hashes from the seeds
        logic              load_hash;  // load dividers from the finished hashes
        logic              div_step;
        logic              rd_a;
        logic              rd_b;
        logic              load_sum;   // load divider with entry sum, modulus n
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_status;

endpackage

### src/mphl_ctrl.sv
// Controller state machine of the lookup unit: clear sweep, key finish sequencing.
// Depends on mphl_pkg.
module mphl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [mphl_pkg::OP_W-1:0]     i_op,
    input  logic                          i_last,
    output logic                          o_in_ready,
    input  mphl_pkg::t_status             i_status,
    output mphl_pkg::t_cmd                o_cmd
);
    import mphl_pkg::*;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_RDA  = 3'd3;
    localparam logic [2:0] ST_RDB  = 3'd4;
    localparam logic [2:0] ST_RDW  = 3'd5;
    localparam logic [2:0] ST_DIV2 = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.clr_addr = r_clr;
        case (r_state)
            ST_CLR: begin
                o_cmd.clear = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_op)
                        OP_WRITE: o_cmd.wr_entry = 1'b1;
                        OP_BYTE: begin
                            o_cmd.byte_step = 1'b1;
                            if (i_last) begin
                                o_cmd.load_hash = 1'b1;
                                n_cnt   = '0;
                                n_state = ST_DIV1;
                            end
                        end
                        OP_EMPTY: begin
                            o_cmd.empty_key = 1'b1;
                            o_cmd.load_hash = 1'b1;
                            n_cnt   = '0;
                            n_state = ST_DIV1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV1: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_W - 1)) n_state = ST_RDA;
            end
            ST_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state = ST_RDB;
            end
            ST_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state = ST_RDW;
            end
            ST_RDW: begin
                o_cmd.load_sum = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV2;
            end
            ST_DIV2: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_STEPS - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_status.out_blocked) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
        end
    end
endmodule

### src/mphl_dpath.sv
// Datapath of the lookup unit: config registers, running hashes, entry table,
// shared restoring remainder units and the output register. Depends on mphl_pkg.
module mphl_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [mphl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mphl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [mphl_pkg::ENT_W-1:0]         i_entry_index,
    input  logic [mphl_pkg::ENT_W-1:0]         i_entry_value,
    input  logic [mphl_pkg::BYTE_W-1:0]        i_key_byte,
    input  mphl_pkg::t_cmd                     i_cmd,
    output mphl_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mphl_pkg::ENT_W-1:0]         o_slot
);
    import mphl_pkg::*;

    logic [HASH_W-1:0] r_seed1, r_seed2;
    logic [MOD_W-1:0]  r_size, r_count;
    logic [HASH_W-1:0] r_h1, r_h2;
    logic              r_open;
    logic [HASH_W-1:0] w_base1, w_base2, w_next1, w_next2;
    logic [MOD_W-1:0]  w_m, w_n;

    logic [ENT_W-1:0]  r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]  r_rdata, r_ent_a;
    logic [ADDR_W-1:0] w_raddr;

    logic [HASH_W-1:0] r_q1, r_q2;
    logic [MOD_W-1:0]  r_r1, r_r2, r_div;
    logic [MOD_W:0]    w_t1, w_t2;
    logic [MOD_W-1:0]  w_sum;

    logic              r_out_valid;
    logic [ENT_W-1:0]  r_slot;

    // clamp moduli into their legal ranges
    always_comb begin
        if (r_size == '0)                        w_m = MOD_W'(1);
        else if (32'(r_size) > TABLE_DEPTH)      w_m = MOD_W'(TABLE_DEPTH);
        else                                     w_m = r_size;
        if (r_count == '0)                       w_n = MOD_W'(1);
        else if (32'(r_count) > MAX_KEYS)        w_n = MOD_W'(MAX_KEYS);
        else                                     w_n = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed1 <= '0;
            r_seed2 <= '0;
            r_size  <= MOD_W'(TABLE_DEPTH);
            r_count <= MOD_W'(MAX_KEYS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED_FIRST:  r_seed1 <= i_cfg_data;
                CFG_SEED_SECOND: r_seed2 <= i_cfg_data;
                CFG_TABLE_SIZE:  r_size  <= i_cfg_data[MOD_W-1:0];
                CFG_KEY_COUNT:   r_count <= i_cfg_data[MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // h*31 + byte as a shift and subtract
    assign w_base1 = r_open ? r_h1 : r_seed1;
    assign w_base2 = r_open ? r_h2 : r_seed2;
    assign w_next1 = (w_base1 << 5) - w_base1 + HASH_W'(i_key_byte);
    assign w_next2 = (w_base2 << 5) - w_base2 + HASH_W'(i_key_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_h1   <= '0;
            r_h2   <= '0;
        end else if (i_cmd.byte_step) begin
            r_h1   <= w_next1;
            r_h2   <= w_next2;
            r_open <= !i_cmd.load_hash;
        end else if (i_cmd.empty_key) begin
            r_h1   <= r_seed1;
            r_h2   <= r_seed2;
            r_open <= 1'b0;
        end
    end

    // entry table, one port; the clear sweep and beat writes share it
    assign w_raddr = i_cmd.rd_b ? ADDR_W'(r_r2) : ADDR_W'(r_r1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[i_cmd.clr_addr] <= '0;
        end else if (i_cmd.wr_entry && (32'(i_entry_index) < TABLE_DEPTH)) begin
            r_mem[ADDR_W'(i_entry_index)] <= i_entry_value;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) r_rdata <= r_mem[w_raddr];
        if (i_cmd.rd_b) r_ent_a <= r_rdata;
    end

    // restoring remainder, one quotient bit per step
    assign w_t1  = {r_r1, r_q1[HASH_W-1]};
    assign w_t2  = {r_r2, r_q2[HASH_W-1]};
    assign w_sum = MOD_W'(r_ent_a) + MOD_W'(r_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hash) begin
            r_q1  <= i_cmd.byte_step ? w_next1 : r_seed1;
            r_q2  <= i_cmd.byte_step ? w_next2 : r_seed2;
            r_r1  <= '0;
            r_r2  <= '0;
            r_div <= w_m;
        end else if (i_cmd.load_sum) begin
            r_q1  <= {w_sum, {(HASH_W-MOD_W){1'b0}}};
            r_r1  <= '0;
            r_div <= w_n;
        end else if (i_cmd.div_step) begin
            r_q1 <= r_q1 << 1;
            r_q2 <= r_q2 << 1;
            r_r1 <= (w_t1 >= {1'b0, r_div}) ? MOD_W'(w_t1 - {1'b0, r_div}) : w_t1[MOD_W-1:0];
            r_r2 <= (w_t2 >= {1'b0, r_div}) ? MOD_W'(w_t2 - {1'b0, r_div}) : w_t2[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) r_slot <= r_r1[ENT_W-1:0];
    end

    assign o_status.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_slot               = r_slot;
endmodule

### src/minimal_perfect_hash_lookup_unit.sv
// Top level of the minimal perfect hash lookup unit: stream ports, config port,
// controller and datapath. Depends on mphl_pkg, mphl_ctrl, mphl_dpath.
//
// After reset the unit clears its 4096-entry table, one entry a cycle, and takes no
// beat until the sweep ends (config writes are taken at once, always). A table
// write or a non-final key byte leaves the unit idle and ready. A final key byte
// or an empty key starts a lookup: 32 steps of the bit-serial remainder that
// reduces both hashes at once, reads of both entries through the single table read
// port, and 13 steps reducing the entry sum modulo the key count, then a load of the
// output register once it is free. Beats are taken again while a finished slot
// waits on the master side.
module minimal_perfect_hash_lookup_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mphl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mphl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [11:0] entry_index, [23:12] entry_value, [31:24] key_byte
    input  logic [mphl_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] op
    input  logic [mphl_pkg::OP_W-1:0]           i_s_tuser,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [11:0] slot, [15:12] zero
    output logic [mphl_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import mphl_pkg::*;

    t_cmd             w_cmd;
    t_status          w_status;
    logic [ENT_W-1:0] w_slot;

    assign o_cfg_ready = 1'b1;

    mphl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_last     (i_s_tlast),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mphl_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_s_tdata[11:0]),
        .i_entry_value (i_s_tdata[23:12]),
        .i_key_byte    (i_s_tdata[31:24]),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_slot        (w_slot)
    );

    assign o_m_tdata = {{(OUT_DATA_W-ENT_W){1'b0}}, w_slot};

    // clear sweep starts right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("beat accepted during clear sweep");

    // loading a slot never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_m_tvalid && !i_m_tready))
        else $error("pending slot overwritten");

    // a finishing beat starts the lookup and drops ready
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && w_cmd.load_hash) |=> !o_s_tready)
        else $error("ready high during lookup");

    a_slot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled slot changed");
endmodule

### dv/mphl_checker.sv
// Checker for the minimal perfect hash lookup unit: watches config, input and output
// channels, predicts slots from a local table and hash copy, compares in order.
// Depends on mphl_pkg.
`timescale 1ns / 100ps
module mphl_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [mphl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mphl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [mphl_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [mphl_pkg::OP_W-1:0]       i_s_tuser,
    input  logic                            i_s_tlast,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [mphl_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                              o_errors,
    output int                              o_pending
);
    import mphl_pkg::*;

    logic [ENT_W-1:0]  entries [TABLE_DEPTH];
    logic [HASH_W-1:0] seed_a, seed_b, run_a, run_b;
    logic [MOD_W-1:0]  tbl_size, key_cnt;
    logic              key_busy;
    logic [ENT_W-1:0]  slot_q [$];

    function automatic logic [ENT_W-1:0] slot_of(logic [HASH_W-1:0] ha, logic [HASH_W-1:0] hb);
        int unsigned m, n, s;
        m = (tbl_size < 1) ? 1 : (tbl_size > TABLE_DEPTH) ? TABLE_DEPTH : tbl_size;
        n = (key_cnt < 1) ? 1 : (key_cnt > MAX_KEYS) ? MAX_KEYS : key_cnt;
        s = entries[ha % m] + entries[hb % m];
        return ENT_W'(s % n);
    endfunction

    assign o_pending = slot_q.size();

    always_ff @(posedge i_clk) begin
        logic [ENT_W-1:0] want;
        if (!i_rst_n) begin
            foreach (entries[i]) entries[i] = '0;
            seed_a = '0; seed_b = '0; run_a = '0; run_b = '0;
            tbl_size = 13'd4096; key_cnt = 13'd4096; key_busy = 1'b0;
            slot_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEED_FIRST:  seed_a = i_cfg_data;
                    CFG_SEED_SECOND: seed_b = i_cfg_data;
                    CFG_TABLE_SIZE:  tbl_size = i_cfg_data[MOD_W-1:0];
                    CFG_KEY_COUNT:   key_cnt = i_cfg_data[MOD_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    OP_WRITE: entries[i_s_tdata[11:0]] = i_s_tdata[23:12];
                    OP_BYTE: begin
                        if (!key_busy) begin
                            run_a = seed_a; run_b = seed_b; key_busy = 1'b1;
                        end
                        run_a = run_a * 31 + i_s_tdata[31:24];
                        run_b = run_b * 31 + i_s_tdata[31:24];
                        if (i_s_tlast) begin
                            key_busy = 1'b0;
                            slot_q.insert(slot_q.size(), slot_of(run_a, run_b));
                        end
                    end
                    OP_EMPTY: begin
                        key_busy = 1'b0; run_a = seed_a; run_b = seed_b;
                        slot_q.insert(slot_q.size(), slot_of(run_a, run_b));
                    end
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (slot_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected slot %0d", i_m_tdata);
                end else begin
                    want = slot_q.pop_front();
                    if (i_m_tdata !== {4'b0, want}) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("slot exp %0d got %0d", want, i_m_tdata);
                    end
                end
            end
        end
    end
endmodule

### dv/tb_minimal_perfect_hash_lookup_unit.sv
// Stimulus top for the minimal perfect hash lookup unit: table loads, keys, config
// phases and backpressure. Depends on mphl_pkg, the unit and mphl_checker.
`timescale 1ns / 100ps
module tb_minimal_perfect_hash_lookup_unit;
    import mphl_pkg::*;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_s_tvalid, o_s_tready, i_s_tlast, o_m_tvalid, i_m_tready;
    logic [IN_DATA_W-1:0] i_s_tdata;
    logic [OP_W-1:0] i_s_tuser;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    int errors, pending, cycles;
    bit calm, hold_sink;

    minimal_perfect_hash_lookup_unit dut (.*);
    mphl_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_s_tlast, .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog bound covers the clear sweep plus the lookup of every finishing beat, with stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 900000) begin
            $display("minimal_perfect_hash_lookup_unit: mismatch");
            $finish;
        end
    end

    // sink: random stall bursts, a long hold when asked
    initial begin
        int n;
        i_m_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                i_m_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_sink = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                i_m_tready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send(logic [OP_W-1:0] op, int unsigned idx, int unsigned val,
                        int unsigned kb, int unsigned lst);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            i_s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= op;
        i_s_tdata  <= {kb[7:0], val[11:0], idx[11:0]};
        i_s_tlast  <= lst[0];
        @(posedge i_clk iff o_s_tready);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_s_tvalid <= 0;
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk iff pending == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic rand_key(int len);
        for (int k = 0; k < len; k++)
            send(OP_BYTE, $urandom, $urandom, $urandom, (k == len - 1) ? 1 : 0);
    endtask

    // mostly writes within the active table and keys; some noise
    task automatic random_phase(int cnt, int m);
        int r;
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 19);
            if (r < 6) send(OP_WRITE, $urandom_range(0, m - 1), $urandom, $urandom, $urandom);
            else if (r < 7) send(OP_WRITE, $urandom, $urandom, $urandom, $urandom);
            else if (r < 16) send(OP_BYTE, $urandom, $urandom, $urandom,
                                  ($urandom_range(0, 2) == 0) ? 1 : 0);
            else if (r < 18) send(OP_EMPTY, $urandom, $urandom, $urandom, $urandom);
            else send(2'd3, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        cycles = 0; calm = 0; hold_sink = 0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_s_tvalid = 0; i_s_tdata = '0; i_s_tuser = '0; i_s_tlast = 0;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: defaults, extremes, special cases
        send(OP_EMPTY, 0, 0, 0, 0);
        send(OP_WRITE, 12'hFFF, 12'hFFF, 8'hFF, 1);
        send(OP_WRITE, 0, 12'hFFF, 0, 0);
        send(OP_BYTE, 12'hFFF, 12'hFFF, 8'hFF, 1);
        send(OP_BYTE, 0, 0, 8'h00, 0);
        send(OP_WRITE, 5, 12'h800, 0, 0);          // write while a key is open
        send(OP_BYTE, 0, 0, 8'hA5, 1);
        send(OP_BYTE, 0, 0, 8'h11, 0);
        send(OP_EMPTY, 0, 0, 0, 0);                 // empty drops the open key
        send(2'd3, 12'hFFF, 12'hFFF, 8'hFF, 1);     // unused op
        rand_key(5);
        drain();
        set_reg(CFG_SEED_FIRST, 32'hFFFF_FFFF);
        set_reg(CFG_SEED_SECOND, 32'h1234_5678);
        set_reg(CFG_TABLE_SIZE, 32'd0);
        set_reg(CFG_KEY_COUNT, 32'd0);
        send(OP_EMPTY, 0, 0, 0, 0);
        rand_key(3);
        drain();
        set_reg(CFG_TABLE_SIZE, 32'h1FFF);
        set_reg(CFG_KEY_COUNT, 32'h1FFF);
        send(OP_BYTE, 0, 0, 8'h42, 0);
        set_reg(CFG_SEED_FIRST, 32'h0);             // seed change inside a key
        send(OP_BYTE, 0, 0, 8'h43, 1);
        send(OP_EMPTY, 0, 0, 0, 0);
        drain();

        // long sink hold while the source keeps offering
        hold_sink = 1;
        random_phase(150, 4096);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            int m;
            m = (ph == 0) ? 1 : (ph == 1) ? 4096 : $urandom_range(2, 64);
            set_reg(CFG_SEED_FIRST, $urandom);
            set_reg(CFG_SEED_SECOND, $urandom);
            set_reg(CFG_TABLE_SIZE, m);
            set_reg(CFG_KEY_COUNT, (ph == 0) ? 1 : (ph == 1) ? 4096 : $urandom_range(1, 300));
            if (ph == 4) calm = 1;
            random_phase(300, m);
            drain();
        end

        if (errors == 0)
            $display("minimal_perfect_hash_lookup_unit: match");
        else
            $display("minimal_perfect_hash_lookup_unit: mismatch");
        $finish;
    end
endmodule

### sim.f
src/mphl_pkg.sv
src/mphl_ctrl.sv
src/mphl_dpath.sv
src/minimal_perfect_hash_lookup_unit.sv
dv/mphl_checker.sv
dv/tb_minimal_perfect_hash_lookup_unit.sv
